// ----- src/dhpm_pkg.sv -----
`default_nettype none

package dhpm_pkg;

   // Field widths
   localparam int unsigned TimeWidth    = 32;
   localparam int unsigned TimeoutWidth = 12;
   localparam int unsigned CountWidth   = 32;
   localparam int unsigned ModeWidth    = 2;
   localparam int unsigned CsrDataWidth = 12;

   // Seconds between keep-alive syncs in anti-park
   localparam logic [TimeWidth-1:0] SyncPeriod = TimeWidth'(30);

   // Register reset values
   localparam logic [TimeoutWidth-1:0] BaseTimeoutReset   = TimeoutWidth'(60);
   localparam logic [TimeoutWidth-1:0] MaxTimeoutReset    = TimeoutWidth'(300);
   localparam logic [TimeoutWidth-1:0] ParkedTimeoutReset = TimeoutWidth'(300);

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_BASE_TIMEOUT     = 2'd0,
      CSR_MAX_TIMEOUT      = 2'd1,
      CSR_PARKED_TIMEOUT   = 2'd2,
      CSR_SYNC_BEFORE_IDLE = 2'd3
   } csr_index_type;

endpackage : dhpm_pkg

`default_nettype wire

// ----- src/disk_head_park_manager_unit.sv -----
// An accepted item goes through the input register, then one step of the mode
// logic into the result register.
// Throughput: one item per cycle while the result is not stalled; the mode/timer
// state is updated in the same cycle the result is registered, so the next item sees it.
// Reset (synchronous, active high): anti-park mode, base timeout 60 s, max and
// parked timeouts 300 s, sync before idle off, timers and head load count 0.
`default_nettype none

module disk_head_park_manager_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // input channel
   input  wire logic                                 req_valid,
   output      logic                                 req_stall,
   input  wire logic [dhpm_pkg::TimeWidth-1:0]       req_now_seconds,
   input  wire logic                                 req_read_seen,
   input  wire logic                                 req_write_seen,
   // result channel
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_stall,
   output      logic                                 rsp_touch_disk,
   output      logic                                 rsp_sync_disks,
   output      logic [dhpm_pkg::ModeWidth-1:0]       rsp_mode_now,
   output      logic [dhpm_pkg::TimeoutWidth-1:0]    rsp_timeout_now,
   output      logic [dhpm_pkg::CountWidth-1:0]      rsp_head_loads,
   // configuration port
   input  wire logic                                 csr_valid,
   output      logic                                 csr_ready,
   input  wire dhpm_pkg::csr_index_type              csr_index,
   input  wire logic [dhpm_pkg::CsrDataWidth-1:0]    csr_data
);
   import dhpm_pkg::*;

   typedef enum logic [ModeWidth-1:0] {
      MODE_ANTIPARK = 2'd0,
      MODE_PARKED   = 2'd1,
      MODE_IDLE     = 2'd2
   } mode_type;

   // Input register
   logic                    in_vld_ff;
   logic [TimeWidth-1:0]    now_ff;
   logic                    read_ff;
   logic                    write_ff;

   // Configuration registers
   logic [TimeoutWidth-1:0] base_timeout_ff,   base_timeout_in;
   logic [TimeoutWidth-1:0] max_timeout_ff,    max_timeout_in;
   logic [TimeoutWidth-1:0] parked_timeout_ff, parked_timeout_in;
   logic                    sync_idle_ff,      sync_idle_in;

   // Manager state
   mode_type                mode_ff,           mode_in;
   logic [TimeWidth-1:0]    timer_start_ff,    timer_start_in;
   logic [TimeoutWidth-1:0] active_timeout_ff, active_timeout_in;
   logic [TimeWidth-1:0]    last_sync_ff,      last_sync_in;
   logic [CountWidth-1:0]   load_ff,           load_in;

   // Result register
   logic                    out_vld_ff,        out_vld_in;
   logic                    touch_ff,          touch_in;
   logic                    sync_ff,           sync_in;

   logic                    move;
   logic                    take_in;
   logic                    cfg_write;
   logic                    activity;
   logic [TimeWidth-1:0]    timer_eff;
   logic [TimeWidth-1:0]    elapsed;
   logic [TimeWidth-1:0]    since_sync;
   logic [TimeoutWidth:0]   doubled;
   logic [CountWidth-1:0]   load_inc;

   // Handshake: the input item moves on when the result register is free
   assign move      = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !move;
   assign take_in   = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign cfg_write = csr_valid && csr_ready;

   // Shared arithmetic; a read in anti-park restarts the timer before the check
   assign activity   = read_ff || write_ff;
   assign timer_eff  = (mode_ff == MODE_ANTIPARK && read_ff) ? now_ff : timer_start_ff;
   assign elapsed    = now_ff - timer_eff;
   assign since_sync = now_ff - last_sync_ff;
   assign doubled    = {active_timeout_ff, 1'b0};
   assign load_inc   = (load_ff != '1) ? load_ff + CountWidth'(1) : load_ff;

   // Next-state logic for one poll sample and for register writes
   always_comb begin
      base_timeout_in   = base_timeout_ff;
      max_timeout_in    = max_timeout_ff;
      parked_timeout_in = parked_timeout_ff;
      sync_idle_in      = sync_idle_ff;
      mode_in           = mode_ff;
      timer_start_in    = timer_start_ff;
      active_timeout_in = active_timeout_ff;
      last_sync_in      = last_sync_ff;
      load_in           = load_ff;
      touch_in          = touch_ff;
      sync_in           = sync_ff;
      out_vld_in        = out_vld_ff && rsp_stall;

      if (cfg_write) begin
         unique case (csr_index)
            CSR_BASE_TIMEOUT: begin
               base_timeout_in   = csr_data[TimeoutWidth-1:0];
               active_timeout_in = csr_data[TimeoutWidth-1:0];
            end
            CSR_MAX_TIMEOUT:      max_timeout_in    = csr_data[TimeoutWidth-1:0];
            CSR_PARKED_TIMEOUT:   parked_timeout_in = csr_data[TimeoutWidth-1:0];
            CSR_SYNC_BEFORE_IDLE: sync_idle_in      = csr_data[0];
            default: ;
         endcase
      end

      if (move) begin
         out_vld_in = 1'b1;
         touch_in   = 1'b0;
         sync_in    = 1'b0;
         unique case (mode_ff)
            MODE_ANTIPARK: begin
               touch_in       = 1'b1;
               timer_start_in = timer_eff;
               if (since_sync > SyncPeriod) begin
                  sync_in      = 1'b1;
                  last_sync_in = now_ff;
               end
               if (elapsed > TimeWidth'(active_timeout_ff)) begin
                  timer_start_in = now_ff;
                  mode_in        = MODE_PARKED;
                  sync_in        = 1'b1;
                  load_in        = load_inc;
               end
            end
            MODE_PARKED: begin
               if (activity) begin
                  // doubled timeout, capped at the maximum
                  active_timeout_in = (doubled > {1'b0, max_timeout_ff}) ?
                                      max_timeout_ff : doubled[TimeoutWidth-1:0];
                  timer_start_in    = now_ff;
                  mode_in           = MODE_ANTIPARK;
               end else if (elapsed > TimeWidth'(parked_timeout_ff)) begin
                  timer_start_in = now_ff;
                  mode_in        = MODE_IDLE;
                  if (sync_idle_ff) begin
                     sync_in = 1'b1;
                     load_in = load_inc;
                  end
               end
            end
            default: begin
               // idle, and the unused code as idle
               if (activity) begin
                  active_timeout_in = base_timeout_ff;
                  timer_start_in    = now_ff;
                  mode_in           = MODE_ANTIPARK;
               end
            end
         endcase
      end
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff         <= 1'b0;
         out_vld_ff        <= 1'b0;
         base_timeout_ff   <= BaseTimeoutReset;
         max_timeout_ff    <= MaxTimeoutReset;
         parked_timeout_ff <= ParkedTimeoutReset;
         sync_idle_ff      <= 1'b0;
         mode_ff           <= MODE_ANTIPARK;
         timer_start_ff    <= '0;
         active_timeout_ff <= BaseTimeoutReset;
         last_sync_ff      <= '0;
         load_ff           <= '0;
      end else begin
         if (!req_stall) begin
            in_vld_ff <= req_valid;
         end
         out_vld_ff        <= out_vld_in;
         base_timeout_ff   <= base_timeout_in;
         max_timeout_ff    <= max_timeout_in;
         parked_timeout_ff <= parked_timeout_in;
         sync_idle_ff      <= sync_idle_in;
         mode_ff           <= mode_in;
         timer_start_ff    <= timer_start_in;
         active_timeout_ff <= active_timeout_in;
         last_sync_ff      <= last_sync_in;
         load_ff           <= load_in;
      end
      // payload
      if (take_in) begin
         now_ff   <= req_now_seconds;
         read_ff  <= req_read_seen;
         write_ff <= req_write_seen;
      end
      touch_ff <= touch_in;
      sync_ff  <= sync_in;
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_touch_disk  = touch_ff;
   assign rsp_sync_disks  = sync_ff;
   assign rsp_mode_now    = mode_ff;
   assign rsp_timeout_now = active_timeout_ff;
   assign rsp_head_loads  = load_ff;

   // Head load count never goes down
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> load_ff >= $past(load_ff))
      else $error("head load count decreased");

   // Manager timers and the head load count only change when an item is processed
   assert property (@(posedge clock) disable iff (reset)
      !move |=> $stable(timer_start_ff) && $stable(last_sync_ff) && $stable(load_ff))
      else $error("manager state changed without an item");

   // An item that leaves the input register shows up as a result
   assert property (@(posedge clock) disable iff (reset)
      move |=> out_vld_ff)
      else $error("processed item lost");

endmodule : disk_head_park_manager_unit

`default_nettype wire
